/* rtl/agsh_pkg.sv */
// ----------------------------------------------------------------------------
// agsh_pkg
// Shared widths, types and helper functions of the angle grey shading pipeline.
// ----------------------------------------------------------------------------
package agsh_pkg;

	localparam int COORD_BITS = 20;
	localparam int REG_BITS   = 20;
	localparam int FRAC_BITS  = 12;
	localparam int BARY_BITS  = 20;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] REG_LIGHT_X = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_LIGHT_Y = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_LIGHT_Z = 2'd2;

	localparam int TD_W  = 2 * COORD_BITS;
	localparam int P_W   = TD_W - FRAC_BITS + 1;
	localparam int V_W   = P_W + 1;
	localparam int EP_W  = 2 * V_W;
	localparam int N_W   = EP_W + 1;
	localparam int LEN_W = 7;
	localparam int SH_W  = 6;
	localparam int RED_LIMIT_BITS = 15;
	localparam int RED_W = RED_LIMIT_BITS + 2;
	localparam int RP_W  = 2 * RED_W;
	localparam int C_W   = RP_W + 1;
	localparam int X_W   = RP_W + 2;
	localparam int MAG_W = 32;
	localparam int SQ_W  = 64;
	localparam int ROOT_W = 32;
	localparam int ISQ_STEPS = 32;

	localparam int CORDIC_STEPS = 19;
	localparam int CX_W = 40;
	localparam int Z_W  = 26;
	localparam logic signed [Z_W-1:0] DEG90 = Z_W'(90 * 65536);
	localparam logic signed [Z_W-1:0] DEG15 = Z_W'(15 * 65536);
	localparam logic [16:0] RECIP_165 = 17'd101681;
	localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;

	localparam logic [BARY_BITS:0] BARY_ONE = 21'd65536;

	typedef struct packed {
		logic hit;
		logic nz;
	} tag_t;

	typedef struct packed {
		logic [SQ_W-1:0] rad;
		logic [SQ_W-1:0] root;
	} isq_t;

	function automatic logic [LEN_W-1:0] bit_len(input logic [N_W-1:0] v);
		logic [LEN_W-1:0] len;
		len = '0;
		for (int i = 0; i < N_W; i++)
			if (v[i])
				len = LEN_W'(i + 1);
		return len;
	endfunction

	function automatic logic [SH_W-1:0] red_shift(input logic [N_W-1:0] v);
		logic [LEN_W-1:0] len;
		len = bit_len(v);
		if (len > LEN_W'(RED_LIMIT_BITS))
			return SH_W'(len - LEN_W'(RED_LIMIT_BITS));
		return '0;
	endfunction

	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		case (i)
			0:  return Z_W'(2949120);
			1:  return Z_W'(1740967);
			2:  return Z_W'(919879);
			3:  return Z_W'(466945);
			4:  return Z_W'(234379);
			5:  return Z_W'(117304);
			6:  return Z_W'(58666);
			7:  return Z_W'(29335);
			8:  return Z_W'(14668);
			9:  return Z_W'(7334);
			10: return Z_W'(3667);
			11: return Z_W'(1833);
			12: return Z_W'(917);
			13: return Z_W'(458);
			14: return Z_W'(229);
			15: return Z_W'(115);
			16: return Z_W'(57);
			17: return Z_W'(29);
			18: return Z_W'(14);
			default: return '0;
		endcase
	endfunction

	function automatic isq_t isq_step(input isq_t s, input logic [SQ_W-1:0] b);
		isq_t o;
		if (s.rad >= s.root + b) begin
			o.rad  = s.rad - (s.root + b);
			o.root = (s.root >> 1) + b;
		end else begin
			o.rad  = s.rad;
			o.root = s.root >> 1;
		end
		return o;
	endfunction

endpackage

/* rtl/agsh_isqrt.sv */
// ----------------------------------------------------------------------------
// agsh_isqrt
// Pipelined integer square root, one result bit per stage; carries x and tag.
// ----------------------------------------------------------------------------
module agsh_isqrt import agsh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic [SQ_W-1:0]       in_rad,
	input  logic signed [X_W-1:0] in_x,
	input  tag_t                  in_tag,
	output logic                  out_v,
	output logic [ROOT_W-1:0]     out_root,
	output logic signed [X_W-1:0] out_x,
	output tag_t                  out_tag
);

	logic                  v_s   [ISQ_STEPS+1];
	isq_t                  st_s  [ISQ_STEPS+1];
	logic signed [X_W-1:0] x_s   [ISQ_STEPS+1];
	tag_t                  tag_s [ISQ_STEPS+1];

	assign v_s[0]   = in_v;
	assign st_s[0]  = '{rad: in_rad, root: '0};
	assign x_s[0]   = in_x;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1]  <= isq_step(st_s[k], BIT);
				x_s[k+1]   <= x_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_v    = v_s[ISQ_STEPS];
	assign out_root = st_s[ISQ_STEPS].root[ROOT_W-1:0];
	assign out_x    = x_s[ISQ_STEPS];
	assign out_tag  = tag_s[ISQ_STEPS];

endmodule

/* rtl/agsh_cordic.sv */
// ----------------------------------------------------------------------------
// agsh_cordic
// Vectoring CORDIC giving the angle of (x, y) in 2^-16 degree, one step a stage.
// ----------------------------------------------------------------------------
module agsh_cordic import agsh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic signed [X_W-1:0] in_x,
	input  logic [ROOT_W-1:0]     in_y,
	input  tag_t                  in_tag,
	output logic                  out_v,
	output logic signed [Z_W-1:0] out_z,
	output tag_t                  out_tag
);

	logic                   v_s   [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] x_s   [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_s   [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_s   [CORDIC_STEPS+1];
	tag_t                   tag_s [CORDIC_STEPS+1];

	// turn by 90 degrees into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			if (in_x < 0) begin
				x_s[0] <= CX_W'({1'b0, in_y});
				y_s[0] <= -CX_W'(in_x);
				z_s[0] <= DEG90;
			end else begin
				x_s[0] <= CX_W'(in_x);
				y_s[0] <= CX_W'({1'b0, in_y});
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q16(i);
				end
			end
		end
	end

	assign out_v   = v_s[CORDIC_STEPS];
	assign out_z   = z_s[CORDIC_STEPS];
	assign out_tag = tag_s[CORDIC_STEPS];

endmodule

/* rtl/angle_grey_shading.sv */
// ----------------------------------------------------------------------------
// angle_grey_shading
// Grey shade of a ray hit from the angle between light vector and face normal.
// Throughput: one request per cycle while in_stall is low; every stage is a
// pipeline register.
// An output register plus one skid entry decouple the sides; in_stall is registered.
// Reset clears all valid bits and the light position to zero.
// ----------------------------------------------------------------------------
module angle_grey_shading import agsh_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_BITS-1:0]        cfg_index,
	input  logic [REG_BITS-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [3*COORD_BITS-1:0]    ray_origin,
	input  logic [3*COORD_BITS-1:0]    ray_direction,
	input  logic signed [COORD_BITS-1:0] hit_distance,
	input  logic signed [BARY_BITS-1:0] bary_u,
	input  logic signed [BARY_BITS-1:0] bary_v,
	input  logic [3*COORD_BITS-1:0]    vertex_b,
	input  logic [3*COORD_BITS-1:0]    vertex_c,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                pixel_argb
);

	logic signed [REG_BITS-1:0] light_q [3];
	logic run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q[0] <= '0;
			light_q[1] <= '0;
			light_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIGHT_X: light_q[0] <= cfg_data;
				REG_LIGHT_Y: light_q[1] <= cfg_data;
				REG_LIGHT_Z: light_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                         v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	tag_t                         tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	tag_t                         tag_s7, tag_s8, tag_s9, tag_s10, tag_s11, tag_s12;
	logic signed [TD_W-1:0]       td_s1 [3];
	logic signed [COORD_BITS-1:0] o_s1 [3], b_s1 [3], c_s1 [3];
	logic signed [V_W-1:0]        r_s2 [3], e1_s2 [3], e2_s2 [3];
	logic signed [V_W-1:0]        r_s3 [3], r_s4 [3], r_s5 [3], r_s6 [3];
	logic signed [EP_W-1:0]       pr_s3 [6];
	logic signed [N_W-1:0]        n_s4 [3], n_s5 [3], n_s6 [3];
	logic [N_W-1:0]               nor_s5;
	logic [V_W-1:0]               ror_s5;
	logic [SH_W-1:0]              sn_s6, sr_s6;
	logic signed [RED_W-1:0]      rr_s7 [3], nn_s7 [3];
	logic signed [RP_W-1:0]       pd_s8 [9];
	logic signed [X_W-1:0]        x_s9, x_s10, x_s11, x_s12;
	logic signed [C_W-1:0]        c_s9 [3];
	logic [MAG_W-1:0]             cm_s10 [3];
	logic [SQ_W-1:0]              sq_s11 [3];
	logic [SQ_W-1:0]              sum_s12;

	logic signed [BARY_BITS:0]    bary_sum;
	logic                         hit_ok;
	logic signed [P_W-1:0]        p_c [3];
	logic signed [TD_W-1:0]       tds_c [3];
	logic signed [N_W-1:0]        n_c [3];
	logic [N_W-1:0]               nor_c;
	logic [V_W-1:0]               ror_c;
	logic signed [C_W-1:0]        c_c [3];

	assign bary_sum = {bary_u[BARY_BITS-1], bary_u} + {bary_v[BARY_BITS-1], bary_v};
	assign hit_ok = (bary_u > 0) && (bary_v > 0) && (bary_sum <= $signed(BARY_ONE));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tds_c[k] = td_s1[k] >>> FRAC_BITS;
			p_c[k]   = P_W'(o_s1[k]) + P_W'(tds_c[k]);
		end
		n_c[0] = N_W'(pr_s3[0]) - N_W'(pr_s3[1]);
		n_c[1] = N_W'(pr_s3[2]) - N_W'(pr_s3[3]);
		n_c[2] = N_W'(pr_s3[4]) - N_W'(pr_s3[5]);
		nor_c = '0;
		ror_c = '0;
		for (int k = 0; k < 3; k++) begin
			nor_c = nor_c | (n_s4[k][N_W-1] ? N_W'(-n_s4[k]) : N_W'(n_s4[k]));
			ror_c = ror_c | (r_s4[k][V_W-1] ? V_W'(-r_s4[k]) : V_W'(r_s4[k]));
		end
		c_c[0] = C_W'(pd_s8[3]) - C_W'(pd_s8[4]);
		c_c[1] = C_W'(pd_s8[5]) - C_W'(pd_s8[6]);
		c_c[2] = C_W'(pd_s8[7]) - C_W'(pd_s8[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
		end else if (run) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10; v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			tag_s1 <= '{hit: hit_ok, nz: 1'b0};
			for (int k = 0; k < 3; k++) begin
				td_s1[k] <= $signed(ray_direction[k*COORD_BITS +: COORD_BITS])
					* hit_distance;
				o_s1[k]  <= ray_origin[k*COORD_BITS +: COORD_BITS];
				b_s1[k]  <= vertex_b[k*COORD_BITS +: COORD_BITS];
				c_s1[k]  <= vertex_c[k*COORD_BITS +: COORD_BITS];
			end

			tag_s2 <= tag_s1;
			for (int k = 0; k < 3; k++) begin
				r_s2[k]  <= V_W'(p_c[k]) - V_W'(light_q[k]);
				e1_s2[k] <= V_W'(b_s1[k]) - V_W'(p_c[k]);
				e2_s2[k] <= V_W'(c_s1[k]) - V_W'(p_c[k]);
			end

			tag_s3   <= tag_s2;
			r_s3     <= r_s2;
			pr_s3[0] <= e1_s2[1] * e2_s2[2];
			pr_s3[1] <= e1_s2[2] * e2_s2[1];
			pr_s3[2] <= e1_s2[2] * e2_s2[0];
			pr_s3[3] <= e1_s2[0] * e2_s2[2];
			pr_s3[4] <= e1_s2[0] * e2_s2[1];
			pr_s3[5] <= e1_s2[1] * e2_s2[0];

			tag_s4 <= tag_s3;
			r_s4   <= r_s3;
			n_s4   <= n_c;

			tag_s5 <= '{hit: tag_s4.hit, nz: (nor_c != '0) && (ror_c != '0)};
			r_s5   <= r_s4;
			n_s5   <= n_s4;
			nor_s5 <= nor_c;
			ror_s5 <= ror_c;

			tag_s6 <= tag_s5;
			r_s6   <= r_s5;
			n_s6   <= n_s5;
			sn_s6  <= red_shift(nor_s5);
			sr_s6  <= red_shift(N_W'(ror_s5));

			tag_s7 <= tag_s6;
			for (int k = 0; k < 3; k++) begin
				rr_s7[k] <= RED_W'(r_s6[k] >>> sr_s6);
				nn_s7[k] <= RED_W'(n_s6[k] >>> sn_s6);
			end

			tag_s8   <= tag_s7;
			pd_s8[0] <= rr_s7[0] * nn_s7[0];
			pd_s8[1] <= rr_s7[1] * nn_s7[1];
			pd_s8[2] <= rr_s7[2] * nn_s7[2];
			pd_s8[3] <= rr_s7[1] * nn_s7[2];
			pd_s8[4] <= rr_s7[2] * nn_s7[1];
			pd_s8[5] <= rr_s7[2] * nn_s7[0];
			pd_s8[6] <= rr_s7[0] * nn_s7[2];
			pd_s8[7] <= rr_s7[0] * nn_s7[1];
			pd_s8[8] <= rr_s7[1] * nn_s7[0];

			tag_s9 <= tag_s8;
			x_s9   <= X_W'(pd_s8[0]) + X_W'(pd_s8[1]) + X_W'(pd_s8[2]);
			c_s9   <= c_c;

			tag_s10 <= tag_s9;
			x_s10   <= x_s9;
			for (int k = 0; k < 3; k++)
				cm_s10[k] <= c_s9[k][C_W-1] ? MAG_W'(-c_s9[k]) : MAG_W'(c_s9[k]);

			tag_s11 <= tag_s10;
			x_s11   <= x_s10;
			for (int k = 0; k < 3; k++)
				sq_s11[k] <= SQ_W'(cm_s10[k]) * SQ_W'(cm_s10[k]);

			tag_s12 <= tag_s11;
			x_s12   <= x_s11;
			sum_s12 <= sq_s11[0] + sq_s11[1] + sq_s11[2];
		end
	end

	logic                  isq_v;
	logic [ROOT_W-1:0]     isq_root;
	logic signed [X_W-1:0] isq_x;
	tag_t                  isq_tag;

	agsh_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (run),
		.in_v     (v_s12),
		.in_rad   (sum_s12),
		.in_x     (x_s12),
		.in_tag   (tag_s12),
		.out_v    (isq_v),
		.out_root (isq_root),
		.out_x    (isq_x),
		.out_tag  (isq_tag)
	);

	logic                  cor_v;
	logic signed [Z_W-1:0] cor_z;
	tag_t                  cor_tag;

	agsh_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (run),
		.in_v    (isq_v),
		.in_x    (isq_x),
		.in_y    (isq_root),
		.in_tag  (isq_tag),
		.out_v   (cor_v),
		.out_z   (cor_z),
		.out_tag (cor_tag)
	);

	logic                  v_f1, v_f2;
	tag_t                  tag_f1, tag_f2;
	logic                  pos_f1, pos_f2;
	logic [31:0]           a_f1;
	logic [33:0]           m_f2;
	logic signed [Z_W-1:0] dang_c;
	logic [8:0]            g_raw;
	logic [7:0]            grey;
	logic [31:0]           pix_c;

	assign dang_c = cor_z - DEG15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (run) begin
			v_f1 <= cor_v;
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			tag_f1 <= cor_tag;
			pos_f1 <= dang_c > 0;
			a_f1   <= 32'(dang_c[23:0]) * 32'd255;
			tag_f2 <= tag_f1;
			pos_f2 <= pos_f1;
			m_f2   <= 34'(a_f1[31:16]) * 34'(RECIP_165);
		end
	end

	assign g_raw = m_f2[32:24];
	assign grey  = (!tag_f2.nz || !pos_f2) ? 8'd0
		: (g_raw > 9'd255) ? 8'd255 : g_raw[7:0];
	assign pix_c = tag_f2.hit ? (ALPHA_OPAQUE | {8'd0, grey, grey, grey}) : 32'd0;

	// output register with one skid entry
	logic        out_v_q, skid_v_q;
	logic [31:0] out_pix_q, skid_pix_q;
	logic        push, take;

	assign run   = !skid_v_q;
	assign push  = run && v_f2;
	assign take  = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || take)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take)
				out_pix_q <= skid_pix_q;
		end else if (push) begin
			if (!out_v_q || take)
				out_pix_q <= pix_c;
			else
				skid_pix_q <= pix_c;
		end
	end

	assign in_stall   = skid_v_q;
	assign out_valid  = out_v_q;
	assign pixel_argb = out_pix_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> !skid_v_q)
		else $error("skid entry not drained after output taken");

	a_pixel_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_pix_q != 32'd0) |->
		(out_pix_q[31:24] == 8'hFF) && (out_pix_q[23:16] == out_pix_q[7:0])
		&& (out_pix_q[15:8] == out_pix_q[7:0]))
		else $error("malformed grey pixel");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams ray hits through angle_grey_shading under random idling on both
// sides and a long output hold-off, predicts each grey pixel and checks
// results in order. The light position is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
	import agsh_pkg::*;

	typedef struct {
		logic [59:0] org;
		logic [59:0] dir;
		logic [19:0] t;
		logic [19:0] u;
		logic [19:0] v;
		logic [59:0] vb;
		logic [59:0] vc;
	} hit_t;

	class shade_board;
		longint light[3];
		logic [31:0] pixels[$];
		int errors;

		function new();
			light = '{0, 0, 0};
			errors = 0;
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %08h want %08h at %0t", what, got, want, $time);
			errors++;
		endfunction

		function longint lane(logic [59:0] w, int k);
			logic signed [19:0] s;
			s = w[k*20 +: 20];
			return longint'(s);
		endfunction

		function void shrink(ref longint a[3]);
			longint unsigned m;
			longint unsigned q;
			int s;
			m = 0;
			s = 0;
			for (int k = 0; k < 3; k++) begin
				q = a[k] < 0 ? longint'(-a[k]) : a[k];
				if (q > m) m = q;
			end
			while ((m >> s) >= 64'd32768) s++;
			for (int k = 0; k < 3; k++) a[k] = a[k] >>> s;
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint angle(longint x, longint y);
			int tab[19] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14};
			longint z;
			longint nx;
			longint ny;
			z = 0;
			if (x < 0) begin
				nx = y;
				y = -x;
				x = nx;
				z = 90 * 65536;
			end
			for (int i = 0; i < 19; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += tab[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= tab[i];
				end
				x = nx;
				y = ny;
			end
			return z;
		endfunction

		function logic [31:0] shade(hit_t h);
			longint t, u, v, p, x, d;
			longint r[3], n[3], e1[3], e2[3];
			longint c[3];
			longint unsigned sq;
			longint unsigned g;
			t = longint'($signed(h.t));
			u = longint'($signed(h.u));
			v = longint'($signed(h.v));
			g = 0;
			if (!(u > 0 && v > 0 && u + v <= 65536)) return 32'h0;
			for (int k = 0; k < 3; k++) begin
				p = lane(h.org, k) + ((t * lane(h.dir, k)) >>> 12);
				r[k] = p - light[k];
				e1[k] = lane(h.vb, k) - p;
				e2[k] = lane(h.vc, k) - p;
			end
			n[0] = e1[1] * e2[2] - e1[2] * e2[1];
			n[1] = e1[2] * e2[0] - e1[0] * e2[2];
			n[2] = e1[0] * e2[1] - e1[1] * e2[0];
			if ((r[0] | r[1] | r[2]) != 0 && (n[0] | n[1] | n[2]) != 0) begin
				shrink(r);
				shrink(n);
				x = r[0] * n[0] + r[1] * n[1] + r[2] * n[2];
				c[0] = r[1] * n[2] - r[2] * n[1];
				c[1] = r[2] * n[0] - r[0] * n[2];
				c[2] = r[0] * n[1] - r[1] * n[0];
				sq = 0;
				for (int k = 0; k < 3; k++) sq += longint'(c[k] * c[k]);
				d = angle(x, longint'(root(sq))) - 15 * 65536;
				if (d > 0) begin
					g = longint'(255 * d) / (165 * 65536);
					if (g > 255) g = 255;
				end
			end
			return ALPHA_OPAQUE | 32'(g << 16) | 32'(g << 8) | 32'(g);
		endfunction

		function void note(hit_t h);
			pixels.push_back(shade(h));
		endfunction

		function void check(logic [31:0] got);
			logic [31:0] want;
			if (pixels.size() == 0) begin
				report("unexpected pixel", got, 32'h0);
				return;
			end
			want = pixels.pop_front();
			if (got !== want) report("pixel_argb", got, want);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = REG_LIGHT_X;
	logic [REG_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [59:0] ray_origin = '0;
	logic [59:0] ray_direction = '0;
	logic signed [19:0] hit_distance = '0;
	logic signed [19:0] bary_u = '0;
	logic signed [19:0] bary_v = '0;
	logic [59:0] vertex_b = '0;
	logic [59:0] vertex_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] pixel_argb;

	shade_board board;
	int send_idle;
	int recv_idle;
	logic hold;

	angle_grey_shading u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ray_origin(ray_origin),
		.ray_direction(ray_direction),
		.hit_distance(hit_distance),
		.bary_u(bary_u),
		.bary_v(bary_v),
		.vertex_b(vertex_b),
		.vertex_c(vertex_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_argb(pixel_argb)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= hold || ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) board.check(pixel_argb);
	end

	function logic [19:0] rand_lane();
		case ($urandom_range(3))
			0: return 20'($urandom);
			1: return 20'($signed($urandom_range(8191)) - 4096);
			2: return 20'($signed($urandom_range(131071)) - 65536);
			default: return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
		endcase
	endfunction

	function logic [59:0] rand_vec();
		return {rand_lane(), rand_lane(), rand_lane()};
	endfunction

	function hit_t rand_hit();
		hit_t h;
		int uu;
		h.org = rand_vec();
		h.dir = rand_vec();
		h.t = rand_lane();
		h.vb = rand_vec();
		h.vc = rand_vec();
		if ($urandom_range(99) < 80) begin
			uu = $urandom_range(65535, 1);
			h.u = 20'(uu);
			h.v = 20'($urandom_range(65536 - uu, 1));
		end else begin
			h.u = 20'($urandom);
			h.v = 20'($urandom);
		end
		return h;
	endfunction

	task send(hit_t h);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ray_origin <= h.org;
		ray_direction <= h.dir;
		hit_distance <= h.t;
		bary_u <= h.u;
		bary_v <= h.v;
		vertex_b <= h.vb;
		vertex_c <= h.vc;
		do @(posedge clk); while (in_stall);
		board.note(h);
	endtask

	task set_light(logic [19:0] x, logic [19:0] y, logic [19:0] z);
		logic [19:0] vals[3];
		vals = '{x, y, z};
		in_valid <= 1'b0;
		while (board.pixels.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		for (int k = 0; k < 3; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_BITS'(k);
			cfg_data <= vals[k];
			@(posedge clk);
			board.light[k] = longint'($signed(vals[k]));
		end
		cfg_we <= 1'b0;
	endtask

	task directed();
		hit_t h;
		h = '{60'h0, 60'h0, 20'h0, 20'd1, 20'd1, 60'h0, 60'h0};
		send(h);
		// zero normal: vertices on the hit point
		h.org = {20'd4096, 20'd0, 20'd0};
		h.vb = h.org;
		h.vc = h.org;
		send(h);
		// zero light vector with a real normal
		h.org = 60'h0;
		h.vb = {20'd0, 20'd0, 20'd4096};
		h.vc = {20'd0, 20'd4096, 20'd0};
		send(h);
		h.org = {20'd0, 20'd0, 20'd8192};
		h.u = 20'd32768;
		h.v = 20'd32768;
		send(h);
		h.org = {20'hFE000, 20'd0, 20'd0};
		send(h);
		h.u = 20'd32768;
		h.v = 20'd32769;
		send(h);
		h.u = 20'd0;
		h.v = 20'd100;
		send(h);
		h.u = 20'd100;
		h.v = 20'd0;
		send(h);
		h.u = 20'h80000;
		h.v = 20'h7FFFF;
		send(h);
		h.u = 20'h7FFFF;
		h.v = 20'h7FFFF;
		send(h);
		h = '{{3{20'h7FFFF}}, {3{20'h7FFFF}}, 20'h7FFFF, 20'd1, 20'd65535,
			{3{20'h80000}}, {20'h7FFFF, 20'h80000, 20'h7FFFF}};
		send(h);
		h = '{{3{20'h80000}}, {3{20'h80000}}, 20'h80000, 20'd65535, 20'd1,
			{3{20'h7FFFF}}, {20'h80000, 20'h7FFFF, 20'h80000}};
		send(h);
		h = '{{20'd0, 20'd0, 20'd0}, {20'd0, 20'd0, 20'd4096}, 20'd4096, 20'd9, 20'd9,
			{20'd4096, 20'd0, 20'd4096}, {20'd0, 20'd4096, 20'd4096}};
		send(h);
		h.dir = {20'd0, 20'd0, 20'hFF000};
		send(h);
		in_valid <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		board = new();
		hold = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_light(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
				1: set_light(20'h80000, 20'h80000, 20'h80000);
				2: set_light(20'h80000, 20'h7FFFF, 20'd0);
				3: set_light(20'd0, 20'd0, 20'd0);
				default: set_light(20'($urandom), 20'($urandom), 20'($urandom));
			endcase
			send_idle = ph < 2 ? 37 : ph < 4 ? 66 : 0;
			recv_idle = ph < 2 ? 66 : ph < 4 ? 37 : 0;
			if (ph == 4) begin
				fork
					begin
						hold = 1'b1;
						repeat (300) @(posedge clk);
						hold = 1'b0;
					end
					for (int i = 0; i < 280; i++) send(rand_hit());
				join
			end else begin
				for (int i = 0; i < 280; i++) send(rand_hit());
			end
			in_valid <= 1'b0;
		end
		while (board.pixels.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
